// ===== rtl/mcf_crc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcf_crc_pkg - shared types and constants of the motor command frame core
// direction codes, frame constants, queue entry type and the crc byte update
// ----------------------------------------------------------------------------
package mcf_crc_pkg;

    // direction codes
    localparam logic [3:0] DirFwd      = 4'd0;
    localparam logic [3:0] DirBack     = 4'd1;
    localparam logic [3:0] DirLeft     = 4'd2;
    localparam logic [3:0] DirRight    = 4'd3;
    localparam logic [3:0] DirTopLeft  = 4'd4;
    localparam logic [3:0] DirTopRight = 4'd5;
    localparam logic [3:0] DirBotLeft  = 4'd6;
    localparam logic [3:0] DirBotRight = 4'd7;
    localparam logic [3:0] DirTurnaway = 4'd8;

    // frame constants
    localparam int unsigned FrameLen  = 9;
    localparam logic [3:0]  LastIdx   = 4'(FrameLen - 1);
    localparam logic [7:0]  SyncByte  = 8'hFF;
    localparam logic [7:0]  SizeByte  = 8'h07;
    localparam logic [7:0]  SlowWheel = 8'h78;
    localparam logic [7:0]  FlagFwd   = 8'hF0;
    localparam logic [7:0]  FlagBack  = 8'hA0;
    localparam logic [7:0]  FlagDiag  = 8'h50;
    localparam logic [7:0]  FlagNone  = 8'h00;
    localparam logic [6:0]  FullPct   = 7'd100;

    // wheel = floor(12 * pct / 5); reciprocal of five in q15
    localparam logic [3:0]  WheelMul  = 4'd12;
    localparam logic [12:0] RecipFive = 13'd6554;

    // crc-16/modbus
    localparam logic [15:0] CrcInit   = 16'hFFFF;
    localparam logic [15:0] CrcPoly   = 16'hA001;

    // queue between front and back
    localparam int unsigned QueueDepth = 2;

    typedef struct packed {
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] flag;
    } wheel_cmd_t;

    typedef struct packed {
        logic       valid;
        wheel_cmd_t cmd;
    } cmd_xfer_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0])
                c = (c >> 1) ^ CrcPoly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mcf_crc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcf_crc_front - command decode
// saturates the speed, scales it to a wheel byte and maps the direction
// ----------------------------------------------------------------------------
module mcf_crc_front (
    input  wire logic                  cmd_valid,
    input  wire logic [3:0]            direction,
    input  wire logic [6:0]            speed_percent,
    output mcf_crc_pkg::cmd_xfer_t     push
);

    logic [6:0]  pct_sat;
    logic [10:0] scaled;
    logic [23:0] prod;
    logic [7:0]  wheel;

    // floor(240 * pct / 100) as floor(12 * pct / 5)
    assign pct_sat = (speed_percent > mcf_crc_pkg::FullPct) ?
                     mcf_crc_pkg::FullPct : speed_percent;
    assign scaled  = 11'(pct_sat) * 11'(mcf_crc_pkg::WheelMul);
    assign prod    = 24'(scaled) * 24'(mcf_crc_pkg::RecipFive);
    assign wheel   = prod[22:15];

    always_comb
    begin
        push.valid = cmd_valid;
        unique case (direction) inside
            mcf_crc_pkg::DirFwd:
            begin
                push.cmd = '{left: wheel, right: wheel, flag: mcf_crc_pkg::FlagFwd};
            end
            mcf_crc_pkg::DirBack:
            begin
                push.cmd = '{left: wheel, right: wheel, flag: mcf_crc_pkg::FlagBack};
            end
            mcf_crc_pkg::DirLeft:
            begin
                push.cmd = '{left: 8'h00, right: wheel, flag: mcf_crc_pkg::FlagFwd};
            end
            mcf_crc_pkg::DirRight:
            begin
                push.cmd = '{left: wheel, right: 8'h00, flag: mcf_crc_pkg::FlagFwd};
            end
            mcf_crc_pkg::DirTopLeft:
            begin
                push.cmd = '{left: mcf_crc_pkg::SlowWheel, right: wheel,
                             flag: mcf_crc_pkg::FlagDiag};
            end
            mcf_crc_pkg::DirTopRight:
            begin
                push.cmd = '{left: wheel, right: mcf_crc_pkg::SlowWheel,
                             flag: mcf_crc_pkg::FlagDiag};
            end
            mcf_crc_pkg::DirBotLeft:
            begin
                push.cmd = '{left: mcf_crc_pkg::SlowWheel, right: wheel,
                             flag: mcf_crc_pkg::FlagNone};
            end
            // turnaway drives like bottom right
            mcf_crc_pkg::DirBotRight, mcf_crc_pkg::DirTurnaway:
            begin
                push.cmd = '{left: wheel, right: mcf_crc_pkg::SlowWheel,
                             flag: mcf_crc_pkg::FlagNone};
            end
            // stop and unknown codes
            default:
            begin
                push.cmd = '{left: 8'h00, right: 8'h00, flag: mcf_crc_pkg::FlagNone};
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/mcf_crc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcf_crc_queue - short command queue
// two-entry fifo decoupling command decode from frame emission
// ----------------------------------------------------------------------------
module mcf_crc_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mcf_crc_pkg::cmd_xfer_t push,
    output logic                       full,
    output mcf_crc_pkg::cmd_xfer_t     head,
    input  wire logic                  pop
);

    localparam int unsigned PtrW = $clog2(mcf_crc_pkg::QueueDepth);
    localparam int unsigned CntW = $clog2(mcf_crc_pkg::QueueDepth + 1);

    mcf_crc_pkg::wheel_cmd_t mem [mcf_crc_pkg::QueueDepth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CntW'(mcf_crc_pkg::QueueDepth));
    assign do_push  = push.valid && !full;
    assign do_pop   = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(mcf_crc_pkg::QueueDepth - 1)) ?
                          '0 : wr_ptr_reg + PtrW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(mcf_crc_pkg::QueueDepth - 1)) ?
                          '0 : rd_ptr_reg + PtrW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CntW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.cmd;
    end

endmodule
`default_nettype wire

// ===== rtl/mcf_crc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcf_crc_back - frame emission
// walks the nine frame bytes of the queue head, folding bytes one to six
// into the crc, into a registered byte output
// ----------------------------------------------------------------------------
module mcf_crc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mcf_crc_pkg::cmd_xfer_t head,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 out_byte,
    output logic                       out_last
);

    logic [3:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        load;
    logic        emit;
    logic [7:0]  cur_byte;

    // the output register takes a byte when empty or being drained
    assign load = !out_valid_reg || out_ready;
    assign emit = load && head.valid;
    assign pop  = emit && (idx_reg == mcf_crc_pkg::LastIdx);

    always_comb
    begin
        case (idx_reg)
            4'd0:    cur_byte = mcf_crc_pkg::SyncByte;
            4'd1:    cur_byte = mcf_crc_pkg::SizeByte;
            4'd2:    cur_byte = head.cmd.left;
            4'd4:    cur_byte = head.cmd.right;
            4'd6:    cur_byte = head.cmd.flag;
            4'd7:    cur_byte = crc_reg[7:0];
            4'd8:    cur_byte = crc_reg[15:8];
            default: cur_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (emit)
        begin
            out_valid_next = 1'b1;
            idx_next = (idx_reg == mcf_crc_pkg::LastIdx) ? 4'd0 : idx_reg + 4'd1;
            if (idx_reg == 4'd0)
                crc_next = mcf_crc_pkg::CrcInit;
            else if (idx_reg <= 4'd6)
                crc_next = mcf_crc_pkg::crc_byte(crc_reg, cur_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= (idx_reg == mcf_crc_pkg::LastIdx);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= mcf_crc_pkg::LastIdx)
        else $error("frame byte index out of range");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (emit && idx_reg == mcf_crc_pkg::LastIdx))
        else $error("queue popped before the frame end");

    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && out_last_reg && idx_reg == 4'd0))
        else $error("frame end not marked on the crc high byte");

    a_no_stray_start: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && idx_reg != mcf_crc_pkg::LastIdx) |=> (idx_reg != 4'd0))
        else $error("frame index wrapped mid frame");

endmodule
`default_nettype wire

// ===== rtl/motor_command_frame_crc16_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// motor_command_frame_crc16_core - wheel command frame builder
// turns a drive command into a nine-byte frame closed by a crc-16/modbus
// ----------------------------------------------------------------------------
//  channel  | role      | tdata                               | tlast
//  ---------+-----------+-------------------------------------+---------------
//  s_*      | command   | [3:0] direction, [10:4] speed_pct   | unused
//  m_*      | frame     | [7:0] frame byte                    | crc high byte
//
//  each command gives nine byte transfers, one per cycle while m_tready is
//  high, so the byte walker in the back end sets the command rate; the first
//  byte of a command passes through the queue and then the output register
//  a two-entry queue holds decoded commands and keeps the head until its
//  last byte leaves, so s_tready stays high until one command waits behind
//  the frame in flight
//  m_tready low holds the output register and the byte walker; the
//  command side keeps taking transfers until the queue fills
//  rst_n clears the queue, the byte index and the output valid
// ----------------------------------------------------------------------------
module motor_command_frame_crc16_core (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // command stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [3:0] direction, [10:4] speed_percent, rest zero

    // frame byte stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] frame_byte
    output logic             m_tlast    // last_byte
);

    mcf_crc_pkg::cmd_xfer_t push;
    mcf_crc_pkg::cmd_xfer_t head;
    logic                   q_full;
    logic                   q_pop;

    // decode: speed scaling and direction table
    mcf_crc_front u_front (
        .cmd_valid     (s_tvalid),
        .direction     (s_tdata[3:0]),
        .speed_percent (s_tdata[10:4]),
        .push          (push)
    );

    // decoded commands wait here while a frame is on the wire
    mcf_crc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (q_pop)
    );

    assign s_tready = !q_full;

    // byte walker with running crc and output register
    mcf_crc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
`default_nettype wire

// ===== tb/motor_command_frame_crc16_core_tb.sv =====
// ----------------------------------------------------------------------------
// motor_command_frame_crc16_core_tb - self-checking bench for the frame core
// drives drive commands into the command stream and checks every frame byte
// against a local frame builder with its own crc-16/modbus, with random
// gaps on the command stream and back-pressure on the frame stream
// ----------------------------------------------------------------------------
module motor_command_frame_crc16_core_tb;

    // cycles with no transfer on either stream before the run is abandoned
    localparam int unsigned StallLimit = 1000;
    // settle time after the last byte, well over the command-to-byte latency
    localparam int unsigned DrainCycles = 16;

    // one expected transfer on the frame byte stream
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'h0000;   // [3:0] direction, [10:4] speed_percent, rest zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;               // [7:0] frame_byte
    logic        m_tlast;               // last_byte

    frame_beat_t expected_beats[$];
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    bit          gaps_enabled = 1'b1;   // random idling on both streams

    motor_command_frame_crc16_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // frame builder: turns one accepted command into its nine expected bytes
    // ------------------------------------------------------------------------
    task automatic build_frame(input logic [3:0] dir, input logic [6:0] pct);
        logic [6:0]  clamped;
        logic [7:0]  wheel;
        logic [7:0]  left;
        logic [7:0]  right;
        logic [7:0]  flag;
        logic [7:0]  bytes [9];
        logic [15:0] crc;
        frame_beat_t beat;

        // speeds above full saturate instead of wrapping
        clamped = (pct > mcf_crc_pkg::FullPct) ? mcf_crc_pkg::FullPct : pct;
        wheel   = 8'((32'd240 * clamped) / 32'd100);

        case (dir)
            mcf_crc_pkg::DirFwd:
            begin
                left = wheel; right = wheel; flag = mcf_crc_pkg::FlagFwd;
            end
            mcf_crc_pkg::DirBack:
            begin
                left = wheel; right = wheel; flag = mcf_crc_pkg::FlagBack;
            end
            mcf_crc_pkg::DirLeft:
            begin
                left = 8'h00; right = wheel; flag = mcf_crc_pkg::FlagFwd;
            end
            mcf_crc_pkg::DirRight:
            begin
                left = wheel; right = 8'h00; flag = mcf_crc_pkg::FlagFwd;
            end
            mcf_crc_pkg::DirTopLeft:
            begin
                left = mcf_crc_pkg::SlowWheel; right = wheel; flag = mcf_crc_pkg::FlagDiag;
            end
            mcf_crc_pkg::DirTopRight:
            begin
                left = wheel; right = mcf_crc_pkg::SlowWheel; flag = mcf_crc_pkg::FlagDiag;
            end
            mcf_crc_pkg::DirBotLeft:
            begin
                left = mcf_crc_pkg::SlowWheel; right = wheel; flag = mcf_crc_pkg::FlagNone;
            end
            mcf_crc_pkg::DirBotRight:
            begin
                left = wheel; right = mcf_crc_pkg::SlowWheel; flag = mcf_crc_pkg::FlagNone;
            end
            mcf_crc_pkg::DirTurnaway:
            begin
                left = wheel; right = mcf_crc_pkg::SlowWheel; flag = mcf_crc_pkg::FlagNone;
            end
            // stop and every unknown code
            default:
            begin
                left = 8'h00; right = 8'h00; flag = mcf_crc_pkg::FlagNone;
            end
        endcase

        bytes[0] = mcf_crc_pkg::SyncByte;
        bytes[1] = mcf_crc_pkg::SizeByte;
        bytes[2] = left;
        bytes[3] = 8'h00;
        bytes[4] = right;
        bytes[5] = 8'h00;
        bytes[6] = flag;

        // crc-16/modbus over the size byte up to the flag byte, lsb first
        crc = mcf_crc_pkg::CrcInit;
        for (int i = 1; i <= 6; i++)
        begin
            crc = crc ^ {8'h00, bytes[i]};
            for (int b = 0; b < 8; b++)
                crc = crc[0] ? ((crc >> 1) ^ mcf_crc_pkg::CrcPoly) : (crc >> 1);
        end
        bytes[7] = crc[7:0];
        bytes[8] = crc[15:8];

        for (int k = 0; k < 9; k++)
        begin
            beat.data = bytes[k];
            beat.last = (k == 8);
            expected_beats.push_back(beat);
        end
    endtask

    // ------------------------------------------------------------------------
    // frame side: random back-pressure, none while gaps are switched off
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= gaps_enabled ? ($urandom_range(0, 99) >= 15) : 1'b1;
    end

    // ------------------------------------------------------------------------
    // monitor: checks each frame byte transfer, predicts each command
    // transfer and watches for a hung stream
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // check first so bytes of a command accepted now never match here
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: stray frame byte: expected none, actual %02h last %0b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    frame_beat_t want;
                    want = expected_beats.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        mismatches++;
                        $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                                 $time, want.data, m_tdata);
                    end
                    if (m_tlast !== want.last)
                    begin
                        mismatches++;
                        $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                                 $time, want.last, m_tlast);
                    end
                end
            end

            if (s_tvalid && s_tready)
                build_frame(s_tdata[3:0], s_tdata[10:4]);

            // watchdog on cycles without any transfer
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= StallLimit)
            begin
                $display("%0t: no transfer for %0d cycles", $time, StallLimit);
                $display("FAIL motor_command_frame_crc16_core");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // command side: one command transfer, with an optional random gap first
    // ------------------------------------------------------------------------
    task automatic send_command(input logic [3:0] dir, input logic [6:0] pct);
        if (gaps_enabled && $urandom_range(0, 99) < 15)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b00000, pct, dir};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // random command: mostly legal directions, a quarter of speeds over full
    task automatic send_random_command();
        logic [3:0] dir;
        logic [6:0] pct;
        dir = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
        pct = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(101, 127))
                                          : 7'($urandom_range(0, 100));
        send_command(dir, pct);
    endtask

    // every direction code once, speeds at the edges of the range
    task automatic test_directed();
        logic [6:0] edge_pct [6];
        edge_pct = '{7'd0, 7'd127, 7'd100, 7'd101, 7'd1, 7'd99};
        for (int d = 0; d < 16; d++)
            send_command(4'(d), edge_pct[d % 6]);
        // full, saturated and zero speed on driven and diagonal directions, then an unknown code
        send_command(mcf_crc_pkg::DirFwd, 7'd127);
        send_command(mcf_crc_pkg::DirFwd, 7'd0);
        send_command(mcf_crc_pkg::DirTopRight, 7'd100);
        send_command(mcf_crc_pkg::DirBotLeft, 7'd127);
        send_command(4'd15, 7'd0);
    endtask

    // back-to-back commands with no command gaps and the frame stream always ready
    task automatic test_no_gaps();
        gaps_enabled = 1'b0;
        for (int n = 0; n < 60; n++)
            send_random_command();
        gaps_enabled = 1'b1;
    endtask

    // a short burst, then hold off until the last frame has left
    task automatic test_drain_pause();
        for (int n = 0; n < 6; n++)
            send_random_command();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    // long random run with gaps on the command stream and back-pressure on the frame stream
    task automatic test_random();
        for (int n = 0; n < 180; n++)
            send_random_command();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_no_gaps();
        test_drain_pause();
        test_random();
        s_tvalid <= 1'b0;

        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (mismatches == 0)
            $display("PASS motor_command_frame_crc16_core");
        else
            $display("FAIL motor_command_frame_crc16_core");
        $finish;
    end

endmodule
